[rtl/q14_fixed_point_alu_assert.svh]
// Assertion macros used by the fixed-point ALU top level.
`ifndef Q14_FIXED_POINT_ALU_ASSERT_SVH
`define Q14_FIXED_POINT_ALU_ASSERT_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define Q14_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("q14 alu check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define Q14_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("q14 alu check failed");

`endif

[rtl/q14alu_pkg.sv]
// Shared types and constants of the Q14 fixed-point ALU.
package q14alu_pkg;

  localparam int DEF_FRAC_BITS = 14;
  localparam int DEF_WORD_BITS = 32;
  localparam int SAT_LIMIT     = 32'h7FFF;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic  valid;
    func_t func;
    logic  quo_neg;
    logic  div_zero;
  } ctl_t;

endpackage

[rtl/q14alu_prep.sv]
// Front stages: operand decode, multiply, add/sub/round and divide setup.
module q14alu_prep #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  q14alu_pkg::func_t               in_func,
  input  logic [31:0]                     in_a,
  input  logic [31:0]                     in_b,
  output q14alu_pkg::ctl_t                ctl,
  output logic [WORD_BITS-1:0]            side,
  output logic [WORD_BITS+FRAC_BITS-1:0]  dvd,
  output logic [WORD_BITS-1:0]            dvsr
);
  import q14alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = WORD_BITS + FRAC_BITS;
  localparam logic signed [W:0]     SAT_P = (W+1)'(SAT_LIMIT);
  localparam logic signed [W:0]     SAT_N = -SAT_P;
  localparam logic signed [2*W-1:0] RND   = (2*W)'(1) <<< (FRAC_BITS - 1);

  logic signed [W-1:0]   a_w, b_w;
  logic        [W-1:0]   a_mag_next, b_mag_next;

  ctl_t                  ctl_a;
  logic signed [W-1:0]   a_r, b_r;
  logic signed [2*W-1:0] prod;
  logic        [W-1:0]   a_mag, b_mag;

  logic signed [W:0]     sum;
  logic signed [2*W-1:0] prod_rnd;
  logic        [W-1:0]   side_next;

  assign a_w = signed'(in_a[W-1:0]);
  assign b_w = signed'(in_b[W-1:0]);
  assign a_mag_next = a_w[W-1] ? W'(-a_w) : W'(a_w);
  assign b_mag_next = b_w[W-1] ? W'(-b_w) : W'(b_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else if (en) begin
      ctl_a.valid <= in_valid;
    end
    if (en) begin
      ctl_a.func     <= in_func;
      // The quotient is negative when exactly one operand is negative, zero counting as positive.
      ctl_a.quo_neg  <= a_w[W-1] ^ b_w[W-1];
      ctl_a.div_zero <= (in_func == FN_DIV) && (b_w == '0);
      a_r            <= a_w;
      b_r            <= b_w;
      prod           <= a_w * b_w;
      a_mag          <= a_mag_next;
      b_mag          <= b_mag_next;
    end
  end

  assign sum      = (W+1)'(a_r) + (W+1)'(b_r);
  assign prod_rnd = (prod + RND) >>> FRAC_BITS;

  always_comb begin
    case (ctl_a.func)
      FN_ADD: begin
        if (sum > SAT_P)      side_next = SAT_P[W-1:0];
        else if (sum < SAT_N) side_next = SAT_N[W-1:0];
        else                  side_next = sum[W-1:0];
      end
      FN_SUB:  side_next = W'(a_r - b_r);
      FN_MUL:  side_next = prod_rnd[W-1:0];
      default: side_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_a.valid;
    end
    if (en) begin
      ctl.func     <= ctl_a.func;
      ctl.quo_neg  <= ctl_a.quo_neg;
      ctl.div_zero <= ctl_a.div_zero;
      side         <= side_next;
      // Rounding adds half the divisor to the dividend's magnitude.
      dvd          <= {a_mag, FRAC_BITS'(0)} + DW'(b_mag >> 1);
      dvsr         <= b_mag;
    end
  end

endmodule

[rtl/q14alu_cell.sv]
// One restoring-division cell: produces one quotient bit per item.
module q14alu_cell #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  q14alu_pkg::ctl_t                ctl_in,
  input  logic [WORD_BITS-1:0]            side_in,
  input  logic [WORD_BITS+FRAC_BITS-1:0]  dvd_in,
  input  logic [WORD_BITS-1:0]            dvsr_in,
  input  logic [WORD_BITS-1:0]            rem_in,
  input  logic [WORD_BITS-1:0]            quo_in,
  output q14alu_pkg::ctl_t                ctl_out,
  output logic [WORD_BITS-1:0]            side_out,
  output logic [WORD_BITS+FRAC_BITS-1:0]  dvd_out,
  output logic [WORD_BITS-1:0]            dvsr_out,
  output logic [WORD_BITS-1:0]            rem_out,
  output logic [WORD_BITS-1:0]            quo_out
);
  import q14alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = WORD_BITS + FRAC_BITS;

  logic [W:0] rem_sh;
  logic [W:0] rem_sub;
  logic       qbit;

  assign rem_sh  = {rem_in, dvd_in[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_in};
  assign qbit    = (rem_sh >= {1'b0, dvsr_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.func     <= ctl_in.func;
      ctl_out.quo_neg  <= ctl_in.quo_neg;
      ctl_out.div_zero <= ctl_in.div_zero;
      side_out         <= side_in;
      dvd_out          <= {dvd_in[DW-2:0], 1'b0};
      dvsr_out         <= dvsr_in;
      rem_out          <= qbit ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_out          <= {quo_in[W-2:0], qbit};
    end
  end

endmodule

[rtl/q14_fixed_point_alu.sv]
// Top level of the Q14 fixed-point ALU: front stages, division cell chain, output register.
//
// Channel   Dir  Payload
// s_axis    in   tdata = operand_a, operand_b; tuser = func
// m_axis    out  tdata = result; tuser = div_by_zero
//
// One request is accepted per cycle while the output register is empty or taken;
// results leave in order. Results pass the front stages, then a chain of division
// cells that yield one quotient bit each, then the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits only.
module q14_fixed_point_alu #(
  parameter int FRAC_BITS = q14alu_pkg::DEF_FRAC_BITS,
  parameter int WORD_BITS = q14alu_pkg::DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result
  output logic        m_axis_tuser    // [0] div_by_zero
);
  import q14alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = WORD_BITS + FRAC_BITS;
  localparam int N  = DW;

  logic en;

  ctl_t          ctl  [N+1];
  logic [W-1:0]  side [N+1];
  logic [DW-1:0] dvd  [N+1];
  logic [W-1:0]  dvsr [N+1];
  logic [W-1:0]  rem  [N+1];
  logic [W-1:0]  quo  [N+1];

  logic [W-1:0]  quo_fix;
  logic [W-1:0]  res_w;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  q14alu_prep #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_func  (func_t'(s_axis_tuser)),
    .in_a     (s_axis_tdata[31:0]),
    .in_b     (s_axis_tdata[63:32]),
    .ctl      (ctl[0]),
    .side     (side[0]),
    .dvd      (dvd[0]),
    .dvsr     (dvsr[0])
  );

  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    q14alu_cell #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[i]),
      .side_in  (side[i]),
      .dvd_in   (dvd[i]),
      .dvsr_in  (dvsr[i]),
      .rem_in   (rem[i]),
      .quo_in   (quo[i]),
      .ctl_out  (ctl[i+1]),
      .side_out (side[i+1]),
      .dvd_out  (dvd[i+1]),
      .dvsr_out (dvsr[i+1]),
      .rem_out  (rem[i+1]),
      .quo_out  (quo[i+1])
    );
  end

  assign quo_fix = ctl[N].quo_neg ? W'(-quo[N]) : quo[N];

  always_comb begin
    if (ctl[N].div_zero)          res_w = '0;
    else if (ctl[N].func == FN_DIV) res_w = quo_fix;
    else                          res_w = side[N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= ctl[N].valid;
    end
    if (en) begin
      m_axis_tdata <= 32'(signed'(res_w));
      m_axis_tuser <= ctl[N].div_zero;
    end
  end

`include "q14_fixed_point_alu_assert.svh"

  `Q14_ASSERT_IMPL(a_dz_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
  `Q14_ASSERT_IMPL(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `Q14_ASSERT_IMPL(a_dz_div, ctl[N].valid && ctl[N].div_zero, ctl[N].func == FN_DIV)
  `Q14_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, ctl[N] == $past(ctl[N]))

endmodule
